FILE: src/tes_pkg.sv
// shared types and constants of the simulation time event scheduler
`default_nettype none

package tes_pkg;

  // default sizes
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TimeBitsDef   = 48;

  // fixed field widths
  localparam int unsigned OpW      = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned PhaseW   = 16;
  localparam int unsigned CountW   = 32;

  // register reset values
  localparam logic [CfgDataW-1:0] TimeStepRst    = 48'd65536;
  localparam logic [PhaseW-1:0]   SampleEveryRst = 16'd1;
  localparam logic [CfgDataW-1:0] StartTimeRst   = 48'd0;

  // item operations
  typedef enum logic [OpW-1:0] {
    OpOrderAbs = 2'd0,
    OpOrderRel = 2'd1,
    OpAdvance  = 2'd2,
    OpRestart  = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StatOk   = 2'd0,
    StatPast = 2'd1,
    StatFull = 2'd2
  } status_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgTimeStep    = 2'd0,
    CfgSampleEvery = 2'd1,
    CfgStartTime   = 2'd2
  } cfg_idx_e;

  // controller states
  typedef enum logic {
    SIdle = 1'b0,
    SExec = 1'b1
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } tes_cmd_t;

endpackage

`default_nettype wire

FILE: src/tes_ctrl.sv
// controller state machine of the scheduler
`default_nettype none

module tes_ctrl
  import tes_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output      logic     busy_o,
  output      logic     done_o,
  output      tes_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   done_q;

  // state register and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.commit;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = SExec;
        end
      end
      SExec: begin
        cmd_o.commit = 1'b1;
        state_d      = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assign busy_o = (state_q == SExec);
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: src/tes_datapath.sv
// datapath: config registers, sorted queue cells, time and counters
`default_nettype none

module tes_datapath
  import tes_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TIME_BITS   = TimeBitsDef,
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tes_cmd_t             cmd_i,
  input  wire logic [OpW-1:0]       op_i,
  input  wire logic [TIME_BITS-1:0] time_value_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  output      logic [StatusW-1:0]   status_o,
  output      logic [TIME_BITS-1:0] current_time_o,
  output      logic                 step_reason_o,
  output      logic                 sample_now_o,
  output      logic [CountW-1:0]    tick_total_o,
  output      logic [CountW-1:0]    ordered_total_o,
  output      logic [CntW-1:0]      pending_count_o
);

  // configuration registers
  logic [CfgDataW-1:0] step_q, start_q;
  logic [PhaseW-1:0]   every_q;

  // captured operands
  op_e                  op_q;
  logic [TIME_BITS-1:0] tord_q, next_q;

  // run state
  logic [TIME_BITS-1:0] cell_q [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] cell_d [QUEUE_DEPTH];
  logic [CntW-1:0]      used_q, used_d;
  logic [TIME_BITS-1:0] now_q, now_d, last_q, last_d;
  logic [CountW-1:0]    tick_q, tick_d, ord_q, ord_d;
  logic [PhaseW-1:0]    phase_q, phase_d;
  status_e              status_q, status_d;
  logic                 reason_q, reason_d, sample_q, sample_d;

  // operand preparation
  logic [TIME_BITS:0]   rel_sum, reg_sum;
  logic [TIME_BITS-1:0] tord_d, next_d;

  // queue control
  logic [QUEUE_DEPTH-1:0] lt;
  logic [TIME_BITS-1:0]   left_val  [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]   right_val [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]   ins_val   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] left_lt;
  logic                   do_insert, do_pop;

  // sample phase
  logic [PhaseW-1:0] every_eff;
  logic [PhaseW:0]   phase_inc;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= TimeStepRst;
      every_q <= SampleEveryRst;
      start_q <= StartTimeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgTimeStep:    step_q  <= cfg_data_i;
        CfgSampleEvery: every_q <= cfg_data_i[PhaseW-1:0];
        CfgStartTime:   start_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturating sums for a relative order and the next regular step
  assign rel_sum = {1'b0, now_q} + {1'b0, time_value_i};
  assign reg_sum = {1'b0, last_q} + {1'b0, TIME_BITS'(step_q)};
  assign tord_d  = (op_e'(op_i) == OpOrderRel)
                   ? (rel_sum[TIME_BITS] ? '1 : rel_sum[TIME_BITS-1:0])
                   : time_value_i;
  assign next_d  = reg_sum[TIME_BITS] ? '1 : reg_sum[TIME_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(op_i);
      tord_q <= tord_d;
      next_q <= next_d;
    end
  end

  // per-cell compare and neighbor selection
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign lt[g] = (CntW'(g) < used_q) && (cell_q[g] < tord_q);
    if (g == 0) begin : g_first
      assign left_lt[g]  = 1'b1;
      assign left_val[g] = tord_q;
    end else begin : g_rest
      assign left_lt[g]  = lt[g-1];
      assign left_val[g] = cell_q[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right_val[g] = cell_q[g];
    end else begin : g_inner
      assign right_val[g] = cell_q[g+1];
    end
    // keep below the insert point, new time at it, shift right above it
    assign ins_val[g] = lt[g] ? cell_q[g] : (left_lt[g] ? tord_q : left_val[g]);
    assign cell_d[g]  = do_insert ? ins_val[g] : (do_pop ? right_val[g] : cell_q[g]);
  end

  assign every_eff = (every_q == '0) ? PhaseW'(1) : every_q;
  assign phase_inc = {1'b0, phase_q} + (PhaseW + 1)'(1);

  // item execution
  always_comb begin
    used_d    = used_q;
    now_d     = now_q;
    last_d    = last_q;
    tick_d    = tick_q;
    ord_d     = ord_q;
    phase_d   = phase_q;
    status_d  = StatOk;
    reason_d  = 1'b0;
    sample_d  = 1'b0;
    do_insert = 1'b0;
    do_pop    = 1'b0;
    case (op_q)
      OpOrderAbs, OpOrderRel: begin
        if (tord_q <= now_q) begin
          status_d = StatPast;
        end else if (used_q == CntW'(QUEUE_DEPTH)) begin
          status_d = StatFull;
        end else begin
          do_insert = 1'b1;
          used_d    = used_q + CntW'(1);
        end
      end
      OpAdvance: begin
        sample_d = (phase_q == '0);
        phase_d  = (phase_inc >= {1'b0, every_eff}) ? '0 : phase_inc[PhaseW-1:0];
        tick_d   = tick_q + CountW'(1);
        if ((used_q != '0) && (next_q >= cell_q[0])) begin
          do_pop = 1'b1;
          used_d = used_q - CntW'(1);
          if (next_q != cell_q[0]) begin
            now_d    = cell_q[0];
            reason_d = 1'b1;
            ord_d    = ord_q + CountW'(1);
          end else begin
            now_d  = next_q;
            last_d = next_q;
          end
        end else begin
          now_d  = next_q;
          last_d = next_q;
        end
      end
      OpRestart: begin
        used_d  = '0;
        now_d   = TIME_BITS'(start_q);
        last_d  = TIME_BITS'(start_q);
        tick_d  = '0;
        ord_d   = '0;
        phase_d = '0;
      end
      default: ;
    endcase
  end

  // run state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      now_q    <= TIME_BITS'(StartTimeRst);
      last_q   <= TIME_BITS'(StartTimeRst);
      tick_q   <= '0;
      ord_q    <= '0;
      phase_q  <= '0;
      status_q <= StatOk;
      reason_q <= 1'b0;
      sample_q <= 1'b0;
    end else if (cmd_i.commit) begin
      used_q   <= used_d;
      now_q    <= now_d;
      last_q   <= last_d;
      tick_q   <= tick_d;
      ord_q    <= ord_d;
      phase_q  <= phase_d;
      status_q <= status_d;
      reason_q <= reason_d;
      sample_q <= sample_d;
    end
  end

  // queue cells
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      cell_q <= cell_d;
    end
  end

  assign status_o        = status_q;
  assign current_time_o  = now_q;
  assign step_reason_o   = reason_q;
  assign sample_now_o    = sample_q;
  assign tick_total_o    = tick_q;
  assign ordered_total_o = ord_q;
  assign pending_count_o = used_q;

endmodule

`default_nettype wire

FILE: src/sim_time_event_scheduler.sv
// simulation time event scheduler: time advance with a sorted queue of ordered times
// a result strobes on done_o after the start transfer, through the execute state and
//   the done register; no new item is taken while busy, when the operand registers
//   hold the item and all queue cells compare and shift in the execute state
// reset: queue empty, time at the start_time reset value, counters zero,
//   registers at their reset values; results cannot be stalled by the receiver
`default_nettype none

module sim_time_event_scheduler
  import tes_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TIME_BITS   = TimeBitsDef,
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire logic [OpW-1:0]       op_i,
  input  wire logic [TIME_BITS-1:0] time_value_i,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  output      logic                 done_o,
  output      logic [StatusW-1:0]   status_o,
  output      logic [TIME_BITS-1:0] current_time_o,
  output      logic                 step_reason_o,
  output      logic                 sample_now_o,
  output      logic [CountW-1:0]    tick_total_o,
  output      logic [CountW-1:0]    ordered_total_o,
  output      logic [CntW-1:0]      pending_count_o
);

  tes_cmd_t cmd;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // controller
  tes_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // datapath
  tes_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (op_i),
    .time_value_i    (time_value_i),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .status_o        (status_o),
    .current_time_o  (current_time_o),
    .step_reason_o   (step_reason_o),
    .sample_now_o    (sample_now_o),
    .tick_total_o    (tick_total_o),
    .ordered_total_o (ordered_total_o),
    .pending_count_o (pending_count_o)
  );

endmodule

`default_nettype wire

FILE: src/tes_checker.sv
// port-level checker of the scheduler and its bind
`default_nettype none

module tes_checker
  import tes_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done_o,
  input wire logic [StatusW-1:0] status_o,
  input wire logic               step_reason_o,
  input wire logic [CntW-1:0]    pending_count_o
);

  // a start transfer makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("start transfer did not raise busy");

  // each busy period ends in exactly one result strobe
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |=> (done_o && !busy))
    else $error("result strobe missing after busy period");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // an ordered-time step is an accepted advance
  a_reason_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && step_reason_o) |-> (status_o == StatOk))
    else $error("ordered step carries a reject status");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pending_count_o <= CntW'(QUEUE_DEPTH)))
    else $error("pending count beyond queue depth");

endmodule

bind sim_time_event_scheduler tes_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tes_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .step_reason_o   (step_reason_o),
  .pending_count_o (pending_count_o)
);

`default_nettype wire

FILE: tb/tb_sim_time_event_scheduler.sv
// self-checking testbench for the simulation time event scheduler
`timescale 1ns / 1ps

module tb_sim_time_event_scheduler;
  import tes_pkg::*;

  localparam int unsigned TW    = TimeBitsDef;
  localparam int unsigned DEPTH = QueueDepthDef;
  localparam int unsigned LIMIT = 200000;
  localparam logic [TW-1:0] TimeMax = '1;
  // register index past the end of the list, must be ignored
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct {
    op_e           op;
    logic [TW-1:0] tv;
  } sched_item_t;

  typedef struct {
    status_e           status;
    logic [TW-1:0]     now;
    logic              reason;
    logic              sample;
    logic [CountW-1:0] ticks;
    logic [CountW-1:0] ordered;
    logic [4:0]        pending;
  } sched_result_t;

  // dut ports
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [OpW-1:0]      op_i = OpAdvance;
  logic [TW-1:0]       time_value_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgTimeStep;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [TW-1:0]       current_time_o;
  logic                step_reason_o;
  logic                sample_now_o;
  logic [CountW-1:0]   tick_total_o;
  logic [CountW-1:0]   ordered_total_o;
  logic [4:0]          pending_count_o;

  // stimulus and expected results
  sched_item_t   item_q[$];
  sched_result_t sched_exp_q[$];
  int unsigned   gap_pct = 25;
  int unsigned   burst_kind = 0;
  int unsigned   burst_left = 0;

  // scheduler shadow state
  logic [TW-1:0]     step_cfg = TimeStepRst;
  logic [PhaseW-1:0] every_cfg = SampleEveryRst;
  logic [TW-1:0]     start_cfg = StartTimeRst;
  logic [TW-1:0]     pend_times[$];
  logic [TW-1:0]     now_t = StartTimeRst;
  logic [TW-1:0]     last_reg_t = StartTimeRst;
  logic [CountW-1:0] tick_cnt = '0;
  logic [CountW-1:0] ord_cnt = '0;
  logic [31:0]       phase_cnt = '0;

  // run statistics
  int unsigned fail_cnt = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_ordered = 0;
  int unsigned n_past = 0;
  int unsigned n_full = 0;
  int unsigned n_restart = 0;
  int unsigned cycle_cnt = 0;

  sim_time_event_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .time_value_i    (time_value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .current_time_o  (current_time_o),
    .step_reason_o   (step_reason_o),
    .sample_now_o    (sample_now_o),
    .tick_total_o    (tick_total_o),
    .ordered_total_o (ordered_total_o),
    .pending_count_o (pending_count_o)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [TW-1:0] rand_time();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [TW-1:0] sat_add(logic [TW-1:0] a, logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? TimeMax : s[TW-1:0];
  endfunction

  // insert into the ascending queue, in front of equal times
  function automatic status_e place_time(logic [TW-1:0] t);
    int pos;
    if (t <= now_t) return StatPast;
    if (pend_times.size() >= DEPTH) return StatFull;
    pos = 0;
    while (pos < pend_times.size() && pend_times[pos] < t) pos++;
    pend_times.insert(pos, t);
    return StatOk;
  endfunction

  // next scheduler state and result for one item
  function automatic sched_result_t sched_predict(op_e op, logic [TW-1:0] tv);
    sched_result_t r;
    logic [TW-1:0] nxt_t;
    logic [31:0]   every;
    r.status = StatOk;
    r.reason = 1'b0;
    r.sample = 1'b0;
    case (op)
      OpOrderAbs: r.status = place_time(tv);
      OpOrderRel: r.status = place_time(sat_add(now_t, tv));
      OpAdvance: begin
        every = (every_cfg == 0) ? 32'd1 : {16'd0, every_cfg};
        nxt_t = sat_add(last_reg_t, step_cfg);
        r.sample = (phase_cnt == 0);
        phase_cnt++;
        if (phase_cnt >= every) phase_cnt = 0;
        if (pend_times.size() > 0 && nxt_t >= pend_times[0]) begin
          // head reached: ordered tick if strictly earlier, else it coincides
          if (nxt_t != pend_times[0]) begin
            now_t = pend_times[0];
            r.reason = 1'b1;
            ord_cnt++;
            n_ordered++;
          end else begin
            now_t = nxt_t;
            last_reg_t = nxt_t;
          end
          void'(pend_times.pop_front());
        end else begin
          now_t = nxt_t;
          last_reg_t = nxt_t;
        end
        tick_cnt++;
      end
      default: begin
        pend_times.delete();
        now_t = start_cfg;
        last_reg_t = start_cfg;
        tick_cnt = '0;
        ord_cnt = '0;
        phase_cnt = '0;
        n_restart++;
      end
    endcase
    if (r.status == StatPast) n_past++;
    if (r.status == StatFull) n_full++;
    r.now = now_t;
    r.ticks = tick_cnt;
    r.ordered = ord_cnt;
    r.pending = 5'(pend_times.size());
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // random item in bursts that fill, drain or mix the queue
  function automatic sched_item_t make_item();
    sched_item_t it;
    int unsigned r;
    int unsigned order_pct;
    logic [TW-1:0] span;
    logic [TW-1:0] delta;
    if (burst_left == 0) begin
      burst_kind = $urandom_range(2);
      burst_left = $urandom_range(30, 8);
    end
    burst_left--;
    order_pct = (burst_kind == 0) ? 70 : (burst_kind == 1) ? 20 : 45;
    span = (step_cfg == 0 || step_cfg > 48'hFF_FFFF) ? 48'h4_0000 : step_cfg << 2;
    delta = rand_time() % span + 1;
    it.tv = rand_time();
    r = $urandom_range(99);
    if (r >= 97) begin
      it.op = OpRestart;
    end else if (r >= order_pct) begin
      it.op = OpAdvance;
    end else if ($urandom_range(1) == 0) begin
      it.op = OpOrderAbs;
      case ($urandom_range(9))
        0: it.tv = rand_time();
        1: it.tv = (pend_times.size() > 0) ?
                   pend_times[$urandom_range(pend_times.size() - 1)] : now_t;
        2: it.tv = sat_add(last_reg_t, step_cfg);
        3: it.tv = now_t;
        4: it.tv = (now_t > delta) ? now_t - delta : '0;
        default: it.tv = sat_add(now_t, delta);
      endcase
    end else begin
      it.op = OpOrderRel;
      case ($urandom_range(9))
        0: it.tv = '0;
        1: it.tv = rand_time();
        2: it.tv = TimeMax;
        default: it.tv = delta;
      endcase
    end
    return it;
  endfunction

  function automatic void push_item(op_e op, logic [TW-1:0] tv);
    sched_item_t it;
    it.op = op;
    it.tv = tv;
    item_q.insert(item_q.size(), it);
  endfunction

  // driver: present the oldest pending item, idling at random
  always @(negedge clk_i) begin
    logic go;
    go = rst_ni && item_q.size() > 0 && ($urandom_range(99) >= gap_pct);
    start <= go;
    if (go) begin
      op_i <= item_q[0].op;
      time_value_i <= item_q[0].tv;
    end
  end

  // monitor: check each result, predict on each item transfer
  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (sched_exp_q.size() == 0) begin
          $error("result transfer with no expected result waiting");
          fail_cnt++;
        end else begin
          want = sched_exp_q.pop_front();
          check_field("status", want.status, status_o);
          check_field("current_time", want.now, current_time_o);
          check_field("step_reason", want.reason, step_reason_o);
          check_field("sample_now", want.sample, sample_now_o);
          check_field("tick_total", want.ticks, tick_total_o);
          check_field("ordered_total", want.ordered, ordered_total_o);
          check_field("pending_count", want.pending, pending_count_o);
          n_results++;
        end
      end
      if (start && !busy) begin
        sched_exp_q.insert(sched_exp_q.size(), sched_predict(op_e'(op_i), time_value_i));
        void'(item_q.pop_front());
        n_items++;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic wait_drained();
    while (item_q.size() != 0 || sched_exp_q.size() != 0) @(posedge clk_i);
  endtask

  // register write transfer, shadow copy updated on acceptance
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgTimeStep:    step_cfg = data;
      CfgSampleEvery: every_cfg = data[PhaseW-1:0];
      CfgStartTime:   start_cfg = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one register setting: restart, then random items
  task automatic run_setting(logic [TW-1:0] step, logic [CfgDataW-1:0] every_data,
                             logic [TW-1:0] t0, int unsigned gap, int unsigned count);
    cfg_write(CfgTimeStep, step);
    cfg_write(CfgSampleEvery, every_data);
    cfg_write(CfgStartTime, t0);
    gap_pct = gap;
    push_item(OpRestart, rand_time());
    repeat (count) begin
      while (item_q.size() >= 4) @(posedge clk_i);
      item_q.insert(item_q.size(), make_item());
    end
    wait_drained();
  endtask

  // main sequence
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed items under reset register values
    push_item(OpAdvance, TimeMax);
    push_item(OpOrderAbs, '0);
    push_item(OpOrderRel, '0);
    push_item(OpOrderRel, TimeMax);
    push_item(OpOrderAbs, TimeMax);
    push_item(OpOrderAbs, 48'h1_8000);
    push_item(OpOrderAbs, 48'h2_0000);
    push_item(OpAdvance, '0);
    push_item(OpAdvance, '0);
    for (int k = 1; k <= 14; k++) push_item(OpOrderRel, TW'(k));
    push_item(OpOrderRel, 48'd1);
    push_item(OpOrderAbs, '0);
    push_item(OpRestart, '0);
    wait_drained();

    // sender idles a quarter of the time
    run_setting(48'h3_0000, 48'd2, '0, 25, 85);
    run_setting(48'd1, 48'hFFFF, TimeMax - 48'h30, 25, 85);
    run_setting('0, 48'd3, 48'd12345, 25, 85);
    // sender idles more than half the time
    cfg_write(CfgUnused, rand_time());
    run_setting(TimeMax, 48'h1234_5678_0000, {16'd0, $urandom}, 55, 85);
    run_setting(48'd7, 48'd5, TimeMax, 55, 40);
    run_setting(TW'($urandom_range(32'h10_0000, 1)), TW'($urandom_range(8, 1)),
                TW'(40'(rand_time())), 55, 85);
    // no idling
    run_setting(48'd2, 48'd16, '0, 0, 100);
    run_setting(48'h1_0000, 48'd1, 48'h100_0000, 0, 100);

    repeat (8) @(posedge clk_i);
    $display("%0d items and %0d results over eight register settings and three idle mixes",
             n_items, n_results);
    $display("%0d ordered ticks, %0d past and %0d full rejections, %0d restarts",
             n_ordered, n_past, n_full, n_restart);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
